### rtl/core/hrd_pkg.sv
package hrd_pkg;

    localparam int LEN_W      = 19;
    localparam int QUEUE_AW   = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [7:0] START_ZERO = 8'h00;
    localparam logic [7:0] START_LAST = 8'h01;

    // One queued command: what one input word turns into on the output side.
    typedef struct packed {
        logic       start_code;
        logic       has_byte;
        logic [7:0] data;
        logic       done;
        logic       key;
    } cmd_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       byte_valid;
        logic       frame_done;
        logic       key_frame;
        logic       run_last;
    } res_t;

endpackage

### rtl/core/hrd_front.sv
module hrd_front
    import hrd_pkg::*;
#(
    parameter logic [LEN_W-1:0] LIMIT_RESET = '0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_first,
    input  logic             in_last,
    output logic             cmd_valid,
    output cmd_t             cmd
);

    localparam logic [4:0] NAL_NON_IDR = 5'd1;
    localparam logic [4:0] NAL_IDR     = 5'd5;
    localparam logic [4:0] NAL_SEI     = 5'd6;
    localparam logic [4:0] NAL_PPS     = 5'd8;
    localparam logic [4:0] NAL_FU_A    = 5'd28;

    typedef enum logic [3:0] {
        KIND_DROP  = 4'b0001,
        KIND_FUA   = 4'b0010,
        KIND_COPY  = 4'b0100,
        KIND_SLICE = 4'b1000
    } kind_t;

    logic [LEN_W-1:0] limit_reg;
    logic [7:0]       fh_reg, fh_next;
    kind_t            kind_reg, kind_next;
    logic [1:0]       pos_reg, pos_next;
    logic             copy_reg, copy_next;
    logic             end_reg, end_next;
    logic             key_reg, key_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic             accept;
    logic [4:0]       nal_type;
    logic             fua_hdr;
    logic             sc;
    logic             hb;
    logic [7:0]       data;
    logic [2:0]       pre_inc;
    logic             post_inc;
    logic [LEN_W:0]   sum_pre;
    logic [LEN_W-1:0] len_pre;
    logic [LEN_W:0]   sum_post;
    logic             copy_ok;
    logic             done;

    assign accept   = in_valid && in_ready;
    assign nal_type = in_byte[4:0];
    assign fua_hdr  = (kind_reg == KIND_FUA) && (pos_reg == 2'd1);

    always_comb begin
        fh_next   = fh_reg;
        kind_next = kind_reg;
        pos_next  = pos_reg;
        copy_next = copy_reg;
        end_next  = end_reg;
        key_next  = key_reg;
        sc        = 1'b0;
        hb        = 1'b0;
        data      = in_byte;
        pre_inc   = 3'd0;
        post_inc  = 1'b0;

        priority if (in_first) begin
            fh_next   = in_byte;
            pos_next  = 2'd1;
            copy_next = 1'b0;
            end_next  = 1'b0;
            key_next  = 1'b0;
            priority if (nal_type == NAL_FU_A) begin
                kind_next = KIND_FUA;
            end else if (nal_type >= NAL_SEI && nal_type <= NAL_PPS) begin
                kind_next = KIND_COPY;
            end else if (nal_type == NAL_NON_IDR || nal_type == NAL_IDR) begin
                kind_next = KIND_SLICE;
                end_next  = 1'b1;
                key_next  = (nal_type == NAL_IDR);
            end else begin
                kind_next = KIND_DROP;
            end
            if (kind_next == KIND_COPY || kind_next == KIND_SLICE) begin
                sc      = 1'b1;
                pre_inc = 3'd4;
            end
        end else if (fua_hdr) begin
            // FU header: rebuild the NAL header from the indicator and FU type
            pos_next = 2'd2;
            sc       = in_byte[7];
            hb       = in_byte[7];
            pre_inc  = in_byte[7] ? 3'd5 : 3'd0;
            data     = {fh_reg[7:5], in_byte[4:0]};
            end_next = in_byte[6];
            key_next = (in_byte[4:0] != NAL_NON_IDR);
        end else if (kind_reg != KIND_DROP) begin
            pos_next = 2'd2;
            hb       = copy_reg;
            post_inc = copy_reg;
        end else begin
            // outside a packet or in a dropped NAL unit: drop the word
            pos_next = pos_reg;
        end

        // Copy decision sees the length after the start code, and also after the rebuilt header for an FU-A start.
        sum_pre = {1'b0, len_reg} + {{(LEN_W-2){1'b0}}, pre_inc};
        len_pre = sum_pre[LEN_W] ? {LEN_W{1'b1}} : sum_pre[LEN_W-1:0];
        copy_ok = len_pre < limit_reg;

        if (in_first && sc) begin
            copy_next = copy_ok;
            hb        = copy_ok;
            post_inc  = copy_ok;
        end else if (!in_first && fua_hdr) begin
            copy_next = copy_ok;
        end

        sum_post = {1'b0, len_pre} + {{LEN_W{1'b0}}, post_inc};

        done = in_last && end_next &&
               ((kind_next == KIND_SLICE) || (kind_next == KIND_FUA && pos_next == 2'd2));

        len_next = done ? '0 : (sum_post[LEN_W] ? {LEN_W{1'b1}} : sum_post[LEN_W-1:0]);
    end

    assign cmd_valid      = accept && (sc || hb || done);
    assign cmd.start_code = sc;
    assign cmd.has_byte   = hb;
    assign cmd.data       = data;
    assign cmd.done       = done;
    assign cmd.key        = key_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            fh_reg    <= '0;
            kind_reg  <= KIND_DROP;
            pos_reg   <= '0;
            copy_reg  <= 1'b0;
            end_reg   <= 1'b0;
            key_reg   <= 1'b0;
            len_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (accept) begin
                fh_reg  <= fh_next;
                len_reg <= len_next;
                if (in_last) begin
                    kind_reg <= KIND_DROP;
                    pos_reg  <= '0;
                    copy_reg <= 1'b0;
                    end_reg  <= 1'b0;
                    key_reg  <= 1'b0;
                end else begin
                    kind_reg <= kind_next;
                    pos_reg  <= pos_next;
                    copy_reg <= copy_next;
                    end_reg  <= end_next;
                    key_reg  <= key_next;
                end
            end
        end
    end

endmodule

### rtl/core/hrd_fifo.sv
module hrd_fifo
    import hrd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            priority if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end else begin
                count_reg <= count_reg;
            end
        end
    end

endmodule

### rtl/core/hrd_back.sv
module hrd_back
    import hrd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cmd_t head,
    input  logic head_valid,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic [2:0] idx_reg;
    logic       valid_reg;
    res_t       res_reg;

    logic [2:0] res_count;
    logic       is_last;
    logic       load;
    res_t       res;

    always_comb begin
        if (head.start_code) begin
            res_count = head.has_byte ? 3'd5 : 3'd4;
        end else begin
            res_count = 3'd1;
        end
        is_last = (idx_reg == res_count - 3'd1);

        res.byte_valid = head.start_code || head.has_byte;
        res.frame_done = is_last && head.done;
        res.key_frame  = is_last && head.done && head.key;
        res.run_last   = is_last;
        priority if (head.start_code && idx_reg < 3'd3) begin
            res.stream_byte = START_ZERO;
        end else if (head.start_code && idx_reg == 3'd3) begin
            res.stream_byte = START_LAST;
        end else if (head.has_byte) begin
            res.stream_byte = head.data;
        end else begin
            res.stream_byte = START_ZERO;
        end
    end

    assign load      = !valid_reg || out_ready;
    assign pop       = head_valid && load && is_last;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= head_valid;
                if (head_valid) begin
                    idx_reg <= is_last ? 3'd0 : idx_reg + 3'd1;
                end
            end
        end
    end

    // advance within a command only while that command sits at the head
    a_idx_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 3'd0) |-> head_valid)
        else $error("result index advanced with empty queue");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= 3'd4)
        else $error("result index out of range");

    a_flag_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !res_reg.byte_valid) |-> (res_reg.frame_done && res_reg.run_last))
        else $error("flag-only word without frame completion");

    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && res_reg.frame_done) |-> res_reg.run_last)
        else $error("frame completion not on last word of run");

endmodule

### rtl/core/h264_rtp_depacketizer.sv
// RTP H.264 payload to Annex B byte stream.
// s_axis carries one payload byte per word; tuser marks the first byte of a
// packet and tlast its last byte. m_axis carries one output word each: a
// start code byte, rebuilt NAL header or payload byte, or a flag-only word
// (tuser[0] low) that reports a completed frame. m_axis_tlast marks the last
// word produced by one input byte; tuser[1] flags frame completion on it and
// tuser[2] a key frame.
// cfg_wr_en/cfg_wr_data write the frame length limit; write it while idle.
// The first output word passes through the command queue and the output register.
// Input is taken at one byte per cycle while each byte yields at most one
// word and the receiver accepts; a packet start yields four or five words,
// one per accepted cycle from the output register, and a 4-entry command
// queue absorbs those runs. s_axis stalls only when that queue is full.
// A receiver stall holds the output register and backs up into the queue.
// Reset clears the queue, the packet state and the frame length, and loads
// the limit with MAX_FRAME_BYTES - 4096, clamped to 0 and to the LEN_W range.
module h264_rtp_depacketizer
    import hrd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 262144
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // payload_byte
    input  logic             s_axis_tuser,   // packet_first
    input  logic             s_axis_tlast,   // packet_last
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // stream_byte
    output logic [2:0]       m_axis_tuser,   // byte_valid, frame_done, key_frame
    output logic             m_axis_tlast,   // run_last
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data     // frame_length_limit
);

    localparam int LimitRaw = (MAX_FRAME_BYTES > 4096) ? MAX_FRAME_BYTES - 4096 : 0;
    localparam int LenMax   = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LIMIT_RESET =
        LEN_W'((LimitRaw > LenMax) ? LenMax : LimitRaw);

    logic cmd_valid;
    cmd_t cmd;
    logic full;
    logic empty;
    logic pop;
    cmd_t head;
    res_t res;

    assign s_axis_tready = !full;

    hrd_front #(
        .LIMIT_RESET (LIMIT_RESET)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_first    (s_axis_tuser),
        .in_last     (s_axis_tlast),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    hrd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_valid),
        .push_cmd (cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    hrd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tdata = res.stream_byte;
    assign m_axis_tuser = {res.key_frame, res.frame_done, res.byte_valid};
    assign m_axis_tlast = res.run_last;

endmodule
